/* rtl/acc9_pkg.sv */
package acc9_pkg;

    localparam int PROGRAM_DEPTH = 1024;
    localparam int PC_W          = $clog2(PROGRAM_DEPTH);
    localparam int REG_CNT       = 8;
    localparam int REG_IDX_W     = 3;
    localparam int DATA_W        = 8;
    localparam int INSTR_W       = 9;
    localparam int LEN_W         = 11;
    localparam int DMEM_DEPTH    = 256;
    localparam int DADDR_W       = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 11;

    typedef logic [PC_W-1:0]      t_pc;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [INSTR_W-1:0]   t_instr;
    typedef logic [DATA_W-1:0]    t_data;
    typedef logic [REG_IDX_W-1:0] t_ridx;
    typedef logic [DADDR_W-1:0]   t_daddr;

    localparam t_ridx ACC_INDEX = REG_IDX_W'(0);
    localparam t_len  LEN_RESET = LEN_W'(PROGRAM_DEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MODE      = 1'b1;

    // top field of the instruction word
    localparam logic [2:0] OP_SYS = 3'b000;
    localparam logic [2:0] OP_ADD = 3'b001;
    localparam logic [2:0] OP_SUB = 3'b010;
    localparam logic [2:0] OP_AND = 3'b011;
    localparam logic [2:0] OP_LSH = 3'b100;
    localparam logic [2:0] OP_RSH = 3'b101;
    localparam logic [2:0] OP_BCS = 3'b110;
    localparam logic [2:0] OP_BA  = 3'b111;

    // mid field under OP_SYS; MID_REG also marks register operand for ALU ops
    localparam logic [2:0] MID_MV   = 3'b000;
    localparam logic [2:0] MID_STR  = 3'b010;
    localparam logic [2:0] MID_LD   = 3'b011;
    localparam logic [2:0] MID_DIST = 3'b100;
    localparam logic [2:0] MID_MIN  = 3'b101;
    localparam logic [2:0] MID_CTL  = 3'b111;
    localparam logic [2:0] MID_REG  = 3'b111;

    localparam logic [2:0] CTL_FIN = 3'b000;
    localparam logic [2:0] CTL_RST = 3'b001;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FIN     = 2'd1,
        ST_ILLEGAL = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef struct packed {
        logic    acc_we;
        t_data   acc_wd;
        logic    reg_we;
        t_ridx   reg_idx;
        t_data   reg_wd;
        logic    mem_we;
        t_daddr  mem_addr;
        t_data   mem_wd;
        logic    flag;
        t_pc     pc;
        t_status status;
    } t_exec;

    // register operands are numbered downward from the top of the file
    function automatic t_ridx reg_sel(input logic [2:0] low);
        return ~low;
    endfunction

endpackage

/* rtl/acc9_in_if.sv */
interface acc9_in_if;
    import acc9_pkg::*;

    logic   valid;
    logic   ready;
    t_instr instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

/* rtl/acc9_out_if.sv */
interface acc9_out_if;
    import acc9_pkg::*;

    logic    valid;
    logic    ready;
    t_pc     next_pc;
    t_data   accumulator;
    logic    condition_flag;
    t_status status;

    modport source (output valid, output next_pc, output accumulator,
                    output condition_flag, output status, input ready);
    modport sink   (input valid, input next_pc, input accumulator,
                    input condition_flag, input status, output ready);
endinterface

/* rtl/accumulator_cpu_9bit_execute.sv */
// Execute stage of an 8-bit accumulator machine with 9-bit instruction words.
//
// i_in carries one instruction per request (valid/ready). o_out returns one
// result per instruction: next pc, accumulator, branch flag and status
// (ok, finished, illegal encoding, pc out of range), in instruction order.
// Configuration (program length, init mode) is written through i_cfg_we /
// i_cfg_index / i_cfg_wdata. The user must write it only while no
// instruction is in flight; the block itself does not enforce this.
//
// A request passes through an input register, then through decode/execute
// into the output register. Throughput is one instruction per cycle while
// the receiver does not stall. The data memory read for an instruction is
// issued as it is accepted, with the operand register taken from the
// next-state value of the instruction executing in that cycle.
//
// Reset clears the register file, pc, flag, the data memory valid bits (all
// memory reads as zero) and the configuration to its defaults.
// When the receiver stalls, the result is held in the output register; the
// input register takes one more instruction and then i_in.ready drops.
module accumulator_cpu_9bit_execute (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    acc9_in_if.sink                             i_in,
    acc9_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [acc9_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [acc9_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import acc9_pkg::*;

    t_data   r_rf [REG_CNT];
    t_data   n_rf [REG_CNT];
    t_pc     r_pc;
    logic    r_flag;
    t_len    r_len;
    logic    r_init;

    logic    r_ins_vld;
    t_instr  r_ins;
    t_data   r_op2;

    logic    r_out_vld;
    t_pc     r_out_pc;
    t_data   r_out_acc;
    logic    r_out_flag;
    t_status r_out_st;

    t_exec   ex;
    t_data   la_op2;
    t_data   ld_data;
    logic    fire;
    logic    accept;

    assign fire       = r_ins_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_ins_vld || fire;
    assign accept     = i_in.valid && i_in.ready;

    acc9_exec u_exec (
        .i_instr   (r_ins),
        .i_pc      (r_pc),
        .i_flag    (r_flag),
        .i_acc     (r_rf[ACC_INDEX]),
        .i_op2     (r_op2),
        .i_ld_data (ld_data),
        .i_len     (r_len),
        .i_init    (r_init),
        .o_res     (ex)
    );

    always_comb begin
        n_rf = r_rf;
        if (fire) begin
            if (ex.reg_we) begin
                n_rf[ex.reg_idx] = ex.reg_wd;
            end
            if (ex.acc_we) begin
                n_rf[ACC_INDEX] = ex.acc_wd;
            end
        end
    end

    // operand register of the incoming instruction, as left by the current one
    assign la_op2 = n_rf[reg_sel(i_in.instruction[2:0])];

    acc9_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (la_op2),
        .i_we      (fire && ex.mem_we),
        .i_waddr   (ex.mem_addr),
        .i_wdata   (ex.mem_wd),
        .o_rd_data (ld_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf      <= '{default: '0};
            r_pc      <= '0;
            r_flag    <= 1'b0;
            r_len     <= LEN_RESET;
            r_init    <= 1'b0;
            r_ins_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rf <= n_rf;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROGRAM_LENGTH: r_len  <= i_cfg_wdata;
                    CFG_INIT_MODE:      r_init <= i_cfg_wdata[0];
                    default:            ;
                endcase
            end
            if (accept) begin
                r_ins_vld <= 1'b1;
            end else if (fire) begin
                r_ins_vld <= 1'b0;
            end
            if (fire) begin
                r_pc      <= ex.pc;
                r_flag    <= ex.flag;
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ins <= i_in.instruction;
            r_op2 <= la_op2;
        end
        if (fire) begin
            r_out_pc   <= ex.pc;
            r_out_acc  <= n_rf[ACC_INDEX];
            r_out_flag <= ex.flag;
            r_out_st   <= ex.status;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.next_pc        = r_out_pc;
    assign o_out.accumulator    = r_out_acc;
    assign o_out.condition_flag = r_out_flag;
    assign o_out.status         = r_out_st;

endmodule

/* rtl/acc9_exec.sv */
module acc9_exec (
    input  acc9_pkg::t_instr i_instr,
    input  acc9_pkg::t_pc    i_pc,
    input  logic             i_flag,
    input  acc9_pkg::t_data  i_acc,
    input  acc9_pkg::t_data  i_op2,
    input  acc9_pkg::t_data  i_ld_data,
    input  acc9_pkg::t_len   i_len,
    input  logic             i_init,
    output acc9_pkg::t_exec  o_res
);
    import acc9_pkg::*;

    localparam logic [PC_W:0] DEPTH_X = (PC_W+1)'(PROGRAM_DEPTH);

    logic [2:0]    top, mid, low;
    logic [5:0]    imm6;
    t_data         opb;
    logic [8:0]    sum9;
    t_data         diff;
    t_data         andv;
    t_data         shl, shr;
    logic [8:0]    sdiff, nsdiff;
    t_data         dist_v, min_v;
    logic          in_range;
    logic [PC_W:0] pc_x, inc_x, fwd_x, mag_x, back_x;
    t_pc           pc_inc, br_target;
    logic          legal, fin, rst, branch;

    assign top  = i_instr[8:6];
    assign mid  = i_instr[5:3];
    assign low  = i_instr[2:0];
    assign imm6 = i_instr[5:0];

    assign in_range = {1'b0, i_pc} < i_len;

    assign opb  = (mid == MID_REG) ? i_op2 : {2'b00, imm6};
    assign sum9 = {1'b0, i_acc} + {1'b0, opb};
    assign diff = i_acc - opb;
    assign andv = i_acc & opb;
    assign shl  = (opb >= 8'd8) ? '0 : t_data'(i_acc << opb[2:0]);
    assign shr  = (opb >= 8'd8) ? '0 : t_data'(i_acc >> opb[2:0]);

    // signed absolute difference, 9 bits hold -255..255
    assign sdiff  = {i_acc[7], i_acc} - {i_op2[7], i_op2};
    assign nsdiff = 9'd0 - sdiff;
    assign dist_v = sdiff[8] ? nsdiff[7:0] : sdiff[7:0];
    assign min_v  = (i_acc < i_op2) ? i_acc : i_op2;

    // pc arithmetic modulo program depth
    assign pc_x   = {1'b0, i_pc};
    assign inc_x  = (pc_x + (PC_W+1)'(1) >= DEPTH_X) ? pc_x + (PC_W+1)'(1) - DEPTH_X
                                                     : pc_x + (PC_W+1)'(1);
    assign fwd_x  = (pc_x + (PC_W+1)'(imm6[4:0]) >= DEPTH_X)
                  ? pc_x + (PC_W+1)'(imm6[4:0]) - DEPTH_X
                  : pc_x + (PC_W+1)'(imm6[4:0]);
    assign mag_x  = (PC_W+1)'(6'd32 - {1'b0, imm6[4:0]});
    assign back_x = (pc_x >= mag_x) ? pc_x - mag_x : pc_x + DEPTH_X - mag_x;
    assign pc_inc    = inc_x[PC_W-1:0];
    assign br_target = imm6[5] ? back_x[PC_W-1:0] : fwd_x[PC_W-1:0];

    always_comb begin
        o_res          = '0;
        o_res.reg_idx  = reg_sel(low);
        o_res.reg_wd   = i_acc;
        o_res.mem_addr = i_op2;
        o_res.mem_wd   = i_acc;
        o_res.flag     = i_flag;
        o_res.pc       = i_pc;
        o_res.status   = ST_OK;
        legal  = 1'b1;
        fin    = 1'b0;
        rst    = 1'b0;
        branch = 1'b0;
        if (!in_range) begin
            o_res.status = ST_RANGE;
        end else begin
            case (top)
                OP_SYS: begin
                    case (mid)
                        MID_CTL: begin
                            case (low)
                                CTL_FIN: fin = 1'b1;
                                CTL_RST: rst = 1'b1;
                                default: legal = 1'b0;
                            endcase
                        end
                        MID_MV: begin
                            // acc write wins when the target is the accumulator
                            o_res.reg_we = 1'b1;
                            o_res.acc_we = 1'b1;
                            o_res.acc_wd = '0;
                        end
                        MID_STR: o_res.mem_we = 1'b1;
                        MID_LD: begin
                            o_res.acc_we = 1'b1;
                            o_res.acc_wd = i_ld_data;
                        end
                        MID_DIST: begin
                            o_res.acc_we = 1'b1;
                            o_res.acc_wd = dist_v;
                        end
                        MID_MIN: begin
                            o_res.acc_we = 1'b1;
                            o_res.acc_wd = min_v;
                        end
                        default: legal = 1'b0;
                    endcase
                end
                OP_ADD: begin
                    o_res.acc_we = 1'b1;
                    o_res.acc_wd = sum9[7:0];
                    o_res.flag   = ~sum9[8];
                end
                OP_SUB: begin
                    o_res.acc_we = 1'b1;
                    o_res.acc_wd = diff;
                    o_res.flag   = |diff;
                end
                OP_AND: begin
                    o_res.acc_we = 1'b1;
                    o_res.acc_wd = andv;
                    o_res.flag   = ~|andv;
                end
                OP_LSH: begin
                    o_res.acc_we = 1'b1;
                    o_res.acc_wd = shl;
                    o_res.flag   = |shl;
                end
                OP_RSH: begin
                    o_res.acc_we = 1'b1;
                    o_res.acc_wd = shr;
                    o_res.flag   = |shr;
                end
                OP_BCS:  branch = i_flag;
                OP_BA:   branch = 1'b1;
                default: legal = 1'b0;
            endcase

            if (!legal) begin
                o_res.acc_we = 1'b0;
                o_res.reg_we = 1'b0;
                o_res.mem_we = 1'b0;
                o_res.flag   = i_flag;
                o_res.status = ST_ILLEGAL;
            end else if ((i_init && i_pc != '0) || (!i_init && !fin)) begin
                if (rst) begin
                    o_res.pc = '0;
                end else if (branch) begin
                    o_res.pc = br_target;
                end else begin
                    o_res.pc = pc_inc;
                end
            end else if (fin) begin
                o_res.status = ST_FIN;
            end
        end
    end

endmodule

/* rtl/acc9_dmem.sv */
module acc9_dmem (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  acc9_pkg::t_daddr i_rd_addr,
    input  logic             i_we,
    input  acc9_pkg::t_daddr i_waddr,
    input  acc9_pkg::t_data  i_wdata,
    output acc9_pkg::t_data  o_rd_data
);
    import acc9_pkg::*;

    t_data                 mem [DMEM_DEPTH];
    logic [DMEM_DEPTH-1:0] r_vld;
    t_data                 r_q;
    logic                  r_vld_q;
    logic                  r_byp;
    t_data                 r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // a write on the same edge as the read is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_vld_q    <= r_vld[i_rd_addr];
            r_byp      <= i_we && (i_waddr == i_rd_addr);
            r_byp_data <= i_wdata;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : (r_vld_q ? r_q : '0);

endmodule

/* rtl/acc9_checker.sv */
module acc9_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [9:0] i_out_pc,
    input logic [7:0] i_out_acc,
    input logic       i_out_flag,
    input logic [1:0] i_out_status
);

    // output register empties on reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // an accepted request reaches the output once the output slot is free
    a_request_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 (!i_out_valid || i_out_ready) |=> i_out_valid)
        else $error("accepted request did not reach the output");

    // stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_pc)
            && $stable(i_out_acc) && $stable(i_out_flag) && $stable(i_out_status)))
        else $error("stalled result changed");

endmodule

bind accumulator_cpu_9bit_execute acc9_checker u_acc9_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_pc     (o_out.next_pc),
    .i_out_acc    (o_out.accumulator),
    .i_out_flag   (o_out.condition_flag),
    .i_out_status (o_out.status)
);
